[hdl/ndft_pkg.sv]
// shared types and constants for the netpbm decimal field tokenizer
package ndft_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned FIELD_W  = 32;
	localparam int unsigned STATUS_W = 2;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_OVERFLOW = 2'd2
	} parse_status_t;

	// character codes the scanner reacts to
	localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
	localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

	localparam int unsigned DIGIT_W = 4;
	localparam int unsigned RADIX   = 10;

	typedef struct packed {
		logic [BYTE_W-1:0] byte_in;
		logic              end_of_input;
	} byte_item_t;

	typedef struct packed {
		logic [FIELD_W-1:0]  field_value;
		logic [STATUS_W-1:0] parse_status;
	} field_item_t;

endpackage

[hdl/ndft_byte_if.sv]
// valid/ready channel carrying header bytes
interface ndft_byte_if import ndft_pkg::*; ();
	logic       valid;
	logic       ready;
	byte_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hdl/ndft_field_if.sv]
// valid/ready channel carrying parsed field results
interface ndft_field_if import ndft_pkg::*; ();
	logic        valid;
	logic        ready;
	field_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hdl/netpbm_decimal_field_tokenizer_unit.sv]
// netpbm header decimal field tokenizer: whitespace/comment skip and decimal accumulate
// an accepted byte's result passes the input and result registers to field_stream
// throughput: one byte item per cycle, set by the combinational phase and x10 accumulate
// step; a waiting result does not block the next byte unless the input stage is also full
// reset: arst_n clears the phase to skipping, the accumulator to zero and both stage
// valid flags; payload registers are not reset
module netpbm_decimal_field_tokenizer_unit import ndft_pkg::*; #(
	parameter int unsigned VALUE_BITS = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	ndft_byte_if.sink    byte_stream,
	ndft_field_if.source field_stream
);

	localparam int unsigned WIDE_W = VALUE_BITS + DIGIT_W;

	typedef enum logic [1:0] {
		PH_SKIP    = 2'd0,
		PH_COMMENT = 2'd1,
		PH_DIGITS  = 2'd2
	} scan_phase_t;

	// input stage
	logic       valid_s1;
	byte_item_t item_s1;

	// scanner state
	scan_phase_t           phase_q;
	logic [VALUE_BITS-1:0] acc_q;

	// result stage
	logic                res_valid_s2;
	logic [FIELD_W-1:0]  res_value_s2;
	logic [STATUS_W-1:0] res_status_s2;

	logic advance_s1;

	// next-state and result logic
	scan_phase_t           phase_d;
	logic [VALUE_BITS-1:0] acc_d;
	logic                  emit;
	logic [FIELD_W-1:0]    emit_value;
	parse_status_t         emit_status;

	logic [BYTE_W-1:0]              b;
	logic                           is_space;
	logic                           is_digit;
	logic                           is_eol;
	logic [DIGIT_W-1:0]             digit;
	logic [WIDE_W-1:0]              acc_x10;
	logic [FIELD_W-1:0]             acc_ext;

	// the stage 1 item moves on whenever the result register is free or draining
	assign advance_s1        = valid_s1 && (!res_valid_s2 || field_stream.ready);
	assign byte_stream.ready = !valid_s1 || advance_s1;

	assign b        = item_s1.byte_in;
	assign is_space = b inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
	assign is_digit = b inside {[CH_ZERO:CH_NINE]};
	assign is_eol   = b inside {CH_LF, CH_CR};
	// '0'..'9' carry their value in the low nibble
	assign digit    = b[DIGIT_W-1:0];

	// acc * 10 + digit, widened so the carry past VALUE_BITS is visible
	assign acc_x10 = (WIDE_W'(acc_q) << 3) + (WIDE_W'(acc_q) << 1) + WIDE_W'(digit);

	// low field bits of the value, zero-extended when VALUE_BITS is narrow
	assign acc_ext = FIELD_W'(acc_q);

	always_comb begin
		phase_d     = phase_q;
		acc_d       = acc_q;
		emit        = 1'b0;
		emit_value  = '0;
		emit_status = ST_OK;
		case (phase_q)
			PH_COMMENT: begin
				if (item_s1.end_of_input) begin
					phase_d     = PH_SKIP;
					emit        = 1'b1;
					emit_status = ST_INVALID;
				end else if (is_eol) begin
					phase_d = PH_SKIP;
				end
			end
			PH_DIGITS: begin
				if (item_s1.end_of_input || is_space) begin
					// value ends at a delimiter or end of input
					phase_d    = PH_SKIP;
					acc_d      = '0;
					emit       = 1'b1;
					emit_value = acc_ext;
				end else if (b == CH_HASH) begin
					// '#' ends the value and opens a comment
					phase_d    = PH_COMMENT;
					acc_d      = '0;
					emit       = 1'b1;
					emit_value = acc_ext;
				end else if (!is_digit) begin
					phase_d     = PH_SKIP;
					acc_d       = '0;
					emit        = 1'b1;
					emit_status = ST_INVALID;
				end else if (|acc_x10[WIDE_W-1:VALUE_BITS]) begin
					phase_d     = PH_SKIP;
					acc_d       = '0;
					emit        = 1'b1;
					emit_status = ST_OVERFLOW;
				end else begin
					acc_d = acc_x10[VALUE_BITS-1:0];
				end
			end
			default: begin
				// skipping whitespace; the unused phase code behaves the same
				phase_d = PH_SKIP;
				if (item_s1.end_of_input) begin
					acc_d       = '0;
					emit        = 1'b1;
					emit_status = ST_INVALID;
				end else if (is_space) begin
					phase_d = PH_SKIP;
				end else if (b == CH_HASH) begin
					phase_d = PH_COMMENT;
				end else if (is_digit) begin
					acc_d   = VALUE_BITS'(digit);
					phase_d = PH_DIGITS;
				end else begin
					acc_d       = '0;
					emit        = 1'b1;
					emit_status = ST_INVALID;
				end
			end
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_stream.ready) begin
			valid_s1 <= byte_stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_stream.ready && byte_stream.valid) begin
			item_s1 <= byte_stream.data;
		end
	end

	// scanner state advances once per item leaving stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
			acc_q   <= '0;
		end else if (advance_s1) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance_s1) begin
			res_valid_s2 <= emit;
		end else if (field_stream.ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && emit) begin
			res_value_s2  <= emit_value;
			res_status_s2 <= emit_status;
		end
	end

	assign field_stream.valid             = res_valid_s2;
	assign field_stream.data.field_value  = res_value_s2;
	assign field_stream.data.parse_status = res_status_s2;

endmodule
